[src/rtb_pkg.sv]
// Package for the rectangle tile binner: sizes, status codes and the entry layout.
// No dependencies.
`default_nettype none
package rtb_pkg;
	localparam int BucketsPerAxis = 8;
	localparam int BucketBits = 3;
	localparam int QueueDepth = 4096;
	localparam int SlotBits = 12;
	localparam int CoordBits = 16;
	localparam int BankBits = 1;
	localparam int MemAddrBits = BankBits + SlotBits;
	localparam int HeadAddrBits = BankBits + 2 * BucketBits;
	localparam int FillBits = SlotBits + 1;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_READ = 2'd1,
		OP_SWAP = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_STORED = 3'd0,
		ST_DROPPED = 3'd1,
		ST_EMPTY = 3'd2,
		ST_SPAN = 3'd3,
		ST_READ = 3'd4,
		ST_SWAPPED = 3'd5
	} status_t;

	localparam logic [2:0] REG_MAP_WIDTH = 3'd0;
	localparam logic [2:0] REG_MAP_DEPTH = 3'd1;
	localparam logic [2:0] REG_X_SHIFT = 3'd2;
	localparam logic [2:0] REG_Z_SHIFT = 3'd3;
	localparam logic [2:0] REG_WRAP = 3'd4;

	typedef struct packed {
		logic [CoordBits-1:0] x;
		logic [CoordBits-1:0] z;
		logic [CoordBits-1:0] w;
		logic [CoordBits-1:0] h;
		logic [31:0] tag;
	} entry_t;

	typedef struct packed {
		status_t status;
		logic [BucketBits-1:0] col;
		logic [BucketBits-1:0] row;
		logic [CoordBits-1:0] x;
		logic [CoordBits-1:0] z;
		logic [CoordBits-1:0] w;
		logic [CoordBits-1:0] h;
		logic [31:0] tag;
		logic [SlotBits-1:0] slot;
		logic [SlotBits-1:0] nxt;
		logic switched;
		logic last;
	} result_t;
endpackage
`default_nettype wire

[src/rect_tile_binner.sv]
// Rectangle tile binner top level: sequencer, piece clipping and list storage.
// Swap and reject results follow accept in the next cycle; a read passes S_RHEAD and S_RDATA.
// An add emits each stored piece through lookup, link, write and result steps, and each
// dropped piece through lookup and result. The block is not ready while an item is at
// work or a result waits. Reset empties all lists in both banks at once through
// per-bucket valid bits; slot memories are not cleared. No clearing pass is needed.
`default_nettype none
module rect_tile_binner
	import rtb_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [1:0] op,
	input wire logic [15:0] rect_x,
	input wire logic [15:0] rect_z,
	input wire logic [15:0] rect_w,
	input wire logic [15:0] rect_h,
	input wire logic [31:0] payload,
	input wire logic [2:0] read_bucket_x,
	input wire logic [2:0] read_bucket_z,
	input wire logic [11:0] read_slot,
	output logic out_valid,
	input wire logic out_stall,
	output logic [2:0] status,
	output logic [2:0] bucket_col,
	output logic [2:0] bucket_row,
	output logic [15:0] piece_x,
	output logic [15:0] piece_z,
	output logic [15:0] piece_w,
	output logic [15:0] piece_h,
	output logic [31:0] piece_payload,
	output logic [11:0] entry_slot,
	output logic [11:0] next_slot,
	output logic bank_switched,
	output logic last,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [16:0] cfg_data
);
	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_PIECE = 7'b0000010,
		S_LINK = 7'b0000100,
		S_WRITE = 7'b0001000,
		S_RHEAD = 7'b0010000,
		S_RDATA = 7'b0100000,
		S_OUT = 7'b1000000
	} state_t;

	localparam int NBk = BucketsPerAxis * BucketsPerAxis;

	state_t state_q;
	logic [16:0] mapw_q, mapd_q;
	logic [4:0] xsh_q, zsh_q;
	logic wrap_q;
	logic bank_q;
	logic [FillBits-1:0] fill_q [2];
	logic [2*NBk-1:0] hvalid_q;

	logic [16:0] x0_q, z0_q, x1_q, z1_q;
	logic [16:0] bx_q, bz_q, bx1_q, bz1_q;
	logic [31:0] tag_q;
	result_t res_q;
	logic [HeadAddrBits-1:0] bk_q;
	logic [SlotBits-1:0] rslot_q;
	logic rbusy_q;
	logic more_q;

	// Clip arithmetic for the current bucket.
	logic [32:0] lox, hix, loz, hiz;
	logic [16:0] sx, sw, sz, sh, mx, mz;
	logic [15:0] px, pz;
	logic [BucketBits-1:0] col, row;
	logic oob;

	always_comb begin
		lox = {16'd0, bx_q} << xsh_q;
		hix = {16'd0, bx_q + 17'd1} << xsh_q;
		loz = {16'd0, bz_q} << zsh_q;
		hiz = {16'd0, bz_q + 17'd1} << zsh_q;
		sx = (lox > {16'd0, x0_q}) ? lox[16:0] : x0_q;
		sz = (loz > {16'd0, z0_q}) ? loz[16:0] : z0_q;
		sw = ((hix < {16'd0, x1_q}) ? hix[16:0] : x1_q) - sx;
		sh = ((hiz < {16'd0, z1_q}) ? hiz[16:0] : z1_q) - sz;
		mx = wrap_q ? (sx & (mapw_q - 17'd1)) : sx;
		mz = wrap_q ? (sz & (mapd_q - 17'd1)) : sz;
		px = mx[15:0];
		pz = mz[15:0];
		col = BucketBits'(px >> xsh_q);
		row = BucketBits'(pz >> zsh_q);
		oob = !wrap_q && (sx >= mapw_q || ({1'b0, sx} + {1'b0, sw}) > {1'b0, mapw_q}
			|| sz >= mapd_q || ({1'b0, sz} + {1'b0, sh}) > {1'b0, mapd_q});
	end

	// Input rectangle span.
	logic [16:0] ix1, iz1, ibx0, ibx1, ibz0, ibz1;
	always_comb begin
		ix1 = {1'b0, rect_x} + {1'b0, rect_w};
		iz1 = {1'b0, rect_z} + {1'b0, rect_h};
		ibx0 = {1'b0, rect_x} >> xsh_q;
		ibx1 = (ix1 - 17'd1) >> xsh_q;
		ibz0 = {1'b0, rect_z} >> zsh_q;
		ibz1 = (iz1 - 17'd1) >> zsh_q;
	end

	// Next result words for an accepted item and for the current piece.
	logic full;
	logic tgt_bank;
	logic [HeadAddrBits-1:0] piece_bk;
	logic ispan;
	result_t idle_res, piece_res;
	always_comb begin
		full = fill_q[bank_q] >= FillBits'(QueueDepth);
		tgt_bank = full ? ~bank_q : bank_q;
		piece_bk = {tgt_bank, row, col};
		ispan = ibx1 - ibx0 >= 17'(BucketsPerAxis) || ibz1 - ibz0 >= 17'(BucketsPerAxis);
		idle_res = '0;
		idle_res.last = 1'b1;
		unique case (op_t'(op))
			OP_SWAP: idle_res.status = ST_SWAPPED;
			OP_READ: begin
				idle_res.status = ST_READ;
				idle_res.col = read_bucket_x;
				idle_res.row = read_bucket_z;
			end
			OP_ADD: idle_res.status = (rect_w == '0 || rect_h == '0) ? ST_EMPTY : ST_SPAN;
			default: ;
		endcase
		piece_res = '0;
		piece_res.status = oob ? ST_DROPPED : ST_STORED;
		piece_res.col = col;
		piece_res.row = row;
		piece_res.x = px;
		piece_res.z = pz;
		piece_res.w = sw[15:0];
		piece_res.h = sh[15:0];
		piece_res.tag = tag_q;
		piece_res.switched = !oob && full;
		piece_res.last = bz_q == bz1_q && bx_q == bx1_q;
	end

	// Memories: entry data and link words, indexed by bank and slot; head and tail slots, by bank and bucket.
	logic ent_we, lnk_we;
	logic [MemAddrBits-1:0] ent_wa, ent_ra, lnk_wa, lnk_ra;
	entry_t ent_wd, ent_rd;
	logic [SlotBits-1:0] lnk_wd, lnk_rd;
	logic tail_we;
	logic [HeadAddrBits-1:0] tail_wa, tail_ra;
	logic [SlotBits-1:0] tail_wd, tail_rd;
	logic head_we;
	logic [HeadAddrBits-1:0] head_wa, head_ra;
	logic [SlotBits-1:0] head_wd, head_rd;

	rtb_ram #(.Width($bits(entry_t)), .Depth(2*QueueDepth)) u_ent (
		.clk, .we(ent_we), .waddr(ent_wa), .wdata(ent_wd), .raddr(ent_ra), .rdata(ent_rd));
	rtb_ram #(.Width(SlotBits), .Depth(2*QueueDepth)) u_lnk (
		.clk, .we(lnk_we), .waddr(lnk_wa), .wdata(lnk_wd), .raddr(lnk_ra), .rdata(lnk_rd));
	rtb_ram #(.Width(SlotBits), .Depth(2*NBk)) u_tail (
		.clk, .we(tail_we), .waddr(tail_wa), .wdata(tail_wd), .raddr(tail_ra),
		.rdata(tail_rd));
	rtb_ram #(.Width(SlotBits), .Depth(2*NBk)) u_head (
		.clk, .we(head_we), .waddr(head_wa), .wdata(head_wd), .raddr(head_ra),
		.rdata(head_rd));

	logic [SlotBits-1:0] cur_slot;
	logic cur_bank;
	logic [HeadAddrBits-1:0] cur_bk;
	logic hempty;
	logic [SlotBits-1:0] rd_slot;
	always_comb begin
		cur_slot = fill_q[bank_q][SlotBits-1:0];
		cur_bank = bank_q;
		cur_bk = bk_q;
		hempty = !hvalid_q[bk_q] || head_rd == '0;
		rd_slot = (rslot_q == '0 && hvalid_q[bk_q]) ? head_rd : rslot_q;
		ent_we = state_q == S_WRITE;
		ent_wa = {cur_bank, cur_slot};
		ent_wd = '{x: res_q.x, z: res_q.z, w: res_q.w, h: res_q.h, tag: res_q.tag};
		ent_ra = {~bank_q, rd_slot};
		lnk_ra = {~bank_q, rd_slot};
		lnk_we = 1'b0;
		lnk_wa = {cur_bank, cur_slot};
		lnk_wd = '0;
		if (state_q == S_LINK && !hempty) begin
			lnk_we = 1'b1;
			lnk_wa = {cur_bank, tail_rd};
			lnk_wd = cur_slot;
		end else if (state_q == S_WRITE) begin
			lnk_we = 1'b1;
		end
		tail_we = state_q == S_WRITE;
		tail_wa = cur_bk;
		tail_wd = cur_slot;
		tail_ra = (state_q == S_PIECE) ? piece_bk : cur_bk;
		head_we = state_q == S_LINK && hempty;
		head_wa = cur_bk;
		head_wd = cur_slot;
		head_ra = (state_q == S_PIECE) ? piece_bk : cur_bk;
	end

	assign in_stall = state_q != S_IDLE || out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mapw_q <= 17'd65536;
			mapd_q <= 17'd65536;
			xsh_q <= 5'd13;
			zsh_q <= 5'd13;
			wrap_q <= 1'b0;
			bank_q <= 1'b0;
			fill_q[0] <= FillBits'(1);
			fill_q[1] <= FillBits'(1);
			hvalid_q <= '0;
			out_valid <= 1'b0;
			rbusy_q <= 1'b0;
			more_q <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MAP_WIDTH: mapw_q <= cfg_data;
					REG_MAP_DEPTH: mapd_q <= cfg_data;
					REG_X_SHIFT: xsh_q <= cfg_data[4:0];
					REG_Z_SHIFT: zsh_q <= cfg_data[4:0];
					REG_WRAP: wrap_q <= cfg_data[0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						res_q <= idle_res;
						unique case (op_t'(op))
							OP_SWAP: begin
								bank_q <= ~bank_q;
								fill_q[~bank_q] <= FillBits'(1);
								for (int i = 0; i < NBk; i++) begin
									hvalid_q[{~bank_q, 6'(i)}] <= 1'b0;
								end
								out_valid <= 1'b1;
							end
							OP_READ: begin
								bk_q <= {~bank_q, read_bucket_z, read_bucket_x};
								rslot_q <= read_slot;
								state_q <= S_RHEAD;
							end
							OP_ADD: begin
								if (rect_w == '0 || rect_h == '0) begin
									out_valid <= 1'b1;
								end else if (ispan) begin
									out_valid <= 1'b1;
								end else begin
									x0_q <= {1'b0, rect_x};
									z0_q <= {1'b0, rect_z};
									x1_q <= ix1;
									z1_q <= iz1;
									bx_q <= ibx0;
									bz_q <= ibz0;
									bx1_q <= ibx1;
									bz1_q <= ibz1;
									tag_q <= payload;
									state_q <= S_PIECE;
								end
							end
							default: ;
						endcase
					end
				end
				S_PIECE: begin
					if (!out_valid) begin
						res_q <= piece_res;
						more_q <= !(bz_q == bz1_q && bx_q == bx1_q);
						if (bx_q == bx1_q) begin
							bx_q <= x0_q >> xsh_q;
							bz_q <= bz_q + 17'd1;
						end else begin
							bx_q <= bx_q + 17'd1;
						end
						if (oob) begin
							out_valid <= 1'b1;
							state_q <= S_OUT;
						end else begin
							if (full) begin
								bank_q <= ~bank_q;
								fill_q[~bank_q] <= FillBits'(1);
								for (int i = 0; i < NBk; i++) begin
									hvalid_q[{~bank_q, 6'(i)}] <= 1'b0;
								end
							end
							bk_q <= piece_bk;
							state_q <= S_LINK;
						end
					end
				end
				S_LINK: begin
					if (hempty) begin
						hvalid_q[bk_q] <= 1'b1;
					end
					state_q <= S_WRITE;
				end
				S_WRITE: begin
					res_q.slot <= cur_slot;
					fill_q[bank_q] <= fill_q[bank_q] + FillBits'(1);
					out_valid <= 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: begin
					state_q <= more_q ? S_PIECE : S_IDLE;
					more_q <= 1'b0;
				end
				S_RHEAD: begin
					rbusy_q <= 1'b1;
					state_q <= S_RDATA;
				end
				S_RDATA: begin
					if (rbusy_q) begin
						rbusy_q <= 1'b0;
						rslot_q <= rd_slot;
					end else begin
						if (rslot_q != '0) begin
							res_q.x <= ent_rd.x;
							res_q.z <= ent_rd.z;
							res_q.w <= ent_rd.w;
							res_q.h <= ent_rd.h;
							res_q.tag <= ent_rd.tag;
							res_q.col <= BucketBits'(ent_rd.x >> xsh_q);
							res_q.row <= BucketBits'(ent_rd.z >> zsh_q);
							res_q.slot <= rslot_q;
							res_q.nxt <= lnk_rd;
						end
						out_valid <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign status = res_q.status;
	assign bucket_col = res_q.col;
	assign bucket_row = res_q.row;
	assign piece_x = res_q.x;
	assign piece_z = res_q.z;
	assign piece_w = res_q.w;
	assign piece_h = res_q.h;
	assign piece_payload = res_q.tag;
	assign entry_slot = res_q.slot;
	assign next_slot = res_q.nxt;
	assign bank_switched = res_q.switched;
	assign last = res_q.last;
endmodule
`default_nettype wire

[src/rtb_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module rtb_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(Depth)-1:0] waddr,
	input wire logic [Width-1:0] wdata,
	input wire logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire
